// ----- src/cap_pkg.sv -----
// Shared opcodes and CORDIC constants for the complex arithmetic polar unit.
`default_nettype none

package cap_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_ADD_REAL = 4'd4,
      OP_SUB_REAL = 4'd5,
      OP_SCALE    = 4'd6,
      OP_DIV_REAL = 4'd7,
      OP_PASS     = 4'd8
   } op_type;

   // Angle accumulator: Q2.30 with headroom for unwrapped sums.
   localparam int ZW          = 36;
   localparam int TBL_FRAC    = 30;
   localparam int GUARD_SHIFT = 16;
   localparam logic signed [ZW-1:0] PI_TBL = 36'sd3373259426;

   // atan(2^-i) in Q2.30, rounded to nearest.
   localparam logic [29:0] ATAN_TBL [32] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
      30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
      30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
      30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
   };

endpackage

`default_nettype wire

// ----- src/complex_arith_polar_unit_top.sv -----
// Throughput: one request per cycle; the pipeline holds every stage while the result waits.
// The long stretches are the restoring divider (one quotient bit per stage), the square root
// (one root bit per stage) and the CORDIC (one rotation per stage).
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none

module complex_arith_polar_unit_top #(
   parameter int DATA_WIDTH   = 16,
   parameter int FRAC_BITS    = 10,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // req_tuser: req_type
   input  wire logic [3:0] req_tuser,
   // req_tdata: a_re, a_im, b_re, b_im, real_operand
   input  wire logic [((5*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // rsp_tuser: overflow, div_by_zero
   output logic [1:0] rsp_tuser,
   // rsp_tdata: res_re, res_im, res_mag, res_angle
   output logic [((4*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata
);

   localparam int W    = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int CS   = CORDIC_STEPS;
   localparam int PW   = 2*W + 2;
   localparam int NUMW = 2*W + 1;
   localparam int QB   = W + 1;
   localparam int DW   = 2*W;
   localparam int RW   = 3*W + F + 2;
   localparam int CW   = W + cap_pkg::GUARD_SHIFT + 3;
   localparam int ZW   = cap_pkg::ZW;
   localparam int SH   = cap_pkg::TBL_FRAC - (W - 3);
   localparam int NST  = 2*W + CS + 12;
   localparam int OW   = ((4*W+7)/8)*8;

   localparam logic signed [PW-1:0] RND_HALF = PW'(1 << (F-1));
   localparam logic signed [PW-1:0] MAXV = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [PW-1:0] MINV = ~MAXV;
   localparam logic [DW-1:0] UMAX = {{W{1'b0}}, {W{1'b1}}};
   localparam logic signed [ZW-1:0] HALFZ = ZW'(1) << (SH-1);
   localparam logic signed [ZW-1:0] PIQ = (cap_pkg::PI_TBL + HALFZ) >>> SH;

   typedef struct packed {
      logic                 isdiv;
      logic                 dbz;
      logic                 neg_re;
      logic                 neg_im;
      logic signed [PW-1:0] val_re;
      logic signed [PW-1:0] val_im;
   } ctl_type;

   typedef struct packed {
      logic signed [W-1:0] re;
      logic signed [W-1:0] im;
      logic                ovf;
      logic                dbz;
   } res_type;

   typedef struct packed {
      res_type     r;
      logic [W-1:0] mag;
      logic        zero;
   } fin_type;

   logic adv;
   logic [NST-1:0] vld_ff;

   assign adv        = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_tvalid};
      end
   end

   logic signed [W-1:0] in_ar, in_ai, in_br, in_bi, in_r;
   assign in_ar = req_tdata[W-1:0];
   assign in_ai = req_tdata[2*W-1:W];
   assign in_br = req_tdata[3*W-1:2*W];
   assign in_bi = req_tdata[4*W-1:3*W];
   assign in_r  = req_tdata[5*W-1:4*W];

   // Stage 1: all partial products.
   cap_pkg::op_type op1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff, r1_ff;
   logic signed [2*W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_ff, p_cc_ff;
   logic signed [2*W-1:0] p_ar_ff, p_ai_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff  <= cap_pkg::op_type'(req_tuser);
         ar1_ff  <= in_ar;
         ai1_ff  <= in_ai;
         br1_ff  <= in_br;
         bi1_ff  <= in_bi;
         r1_ff   <= in_r;
         p_rr_ff <= in_ar * in_br;
         p_ii_ff <= in_ai * in_bi;
         p_ri_ff <= in_ar * in_bi;
         p_ir_ff <= in_ai * in_br;
         p_bb_ff <= in_br * in_br;
         p_cc_ff <= in_bi * in_bi;
         p_ar_ff <= in_ar * in_r;
         p_ai_ff <= in_ai * in_r;
      end
   end

   // Stage 2: sums of products.
   cap_pkg::op_type op2_ff;
   logic signed [W-1:0] ar2_ff, ai2_ff, br2_ff, bi2_ff, r2_ff;
   logic signed [NUMW-1:0] mre2_ff, mim2_ff, nre2_ff, nim2_ff;
   logic signed [2*W-1:0] par2_ff, pai2_ff;
   logic [DW-1:0] den2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         op2_ff  <= op1_ff;
         ar2_ff  <= ar1_ff;
         ai2_ff  <= ai1_ff;
         br2_ff  <= br1_ff;
         bi2_ff  <= bi1_ff;
         r2_ff   <= r1_ff;
         mre2_ff <= NUMW'(p_rr_ff) - NUMW'(p_ii_ff);
         mim2_ff <= NUMW'(p_ri_ff) + NUMW'(p_ir_ff);
         nre2_ff <= NUMW'(p_rr_ff) + NUMW'(p_ii_ff);
         nim2_ff <= NUMW'(p_ir_ff) - NUMW'(p_ri_ff);
         den2_ff <= DW'(p_bb_ff + p_cc_ff);
         par2_ff <= p_ar_ff;
         pai2_ff <= p_ai_ff;
      end
   end

   // Stage 3: opcode decode, rounding of products, divider operands.
   ctl_type ctl3_in, ctl3_ff;
   logic [NUMW-1:0] anre3_in, anim3_in, anre3_ff, anim3_ff;
   logic [DW-1:0] d3_in, d3_ff;
   logic signed [NUMW-1:0] num_re, num_im;
   logic isdiv, realdiv, dbz3;
   logic [W-1:0] abs_r;

   always_comb begin
      ctl3_in.val_re = PW'(ar2_ff);
      ctl3_in.val_im = PW'(ai2_ff);
      isdiv   = 1'b0;
      realdiv = 1'b0;
      case (op2_ff)
         cap_pkg::OP_ADD: begin
            ctl3_in.val_re = PW'(ar2_ff) + PW'(br2_ff);
            ctl3_in.val_im = PW'(ai2_ff) + PW'(bi2_ff);
         end
         cap_pkg::OP_SUB: begin
            ctl3_in.val_re = PW'(ar2_ff) - PW'(br2_ff);
            ctl3_in.val_im = PW'(ai2_ff) - PW'(bi2_ff);
         end
         cap_pkg::OP_MUL: begin
            ctl3_in.val_re = (PW'(mre2_ff) + RND_HALF) >>> F;
            ctl3_in.val_im = (PW'(mim2_ff) + RND_HALF) >>> F;
         end
         cap_pkg::OP_DIV: begin
            isdiv = 1'b1;
         end
         cap_pkg::OP_ADD_REAL: begin
            ctl3_in.val_re = PW'(ar2_ff) + PW'(r2_ff);
         end
         cap_pkg::OP_SUB_REAL: begin
            ctl3_in.val_re = PW'(ar2_ff) - PW'(r2_ff);
         end
         cap_pkg::OP_SCALE: begin
            ctl3_in.val_re = (PW'(par2_ff) + RND_HALF) >>> F;
            ctl3_in.val_im = (PW'(pai2_ff) + RND_HALF) >>> F;
         end
         cap_pkg::OP_DIV_REAL: begin
            isdiv   = 1'b1;
            realdiv = 1'b1;
         end
         default: begin
         end
      endcase

      abs_r = r2_ff[W-1] ? W'(-r2_ff) : W'(r2_ff);
      if (realdiv) begin
         num_re         = NUMW'(ar2_ff);
         num_im         = NUMW'(ai2_ff);
         d3_in          = DW'(abs_r);
         dbz3           = (r2_ff == '0);
         ctl3_in.neg_re = ar2_ff[W-1] ^ r2_ff[W-1];
         ctl3_in.neg_im = ai2_ff[W-1] ^ r2_ff[W-1];
      end else begin
         num_re         = nre2_ff;
         num_im         = nim2_ff;
         d3_in          = den2_ff;
         dbz3           = (den2_ff == '0);
         ctl3_in.neg_re = nre2_ff[NUMW-1];
         ctl3_in.neg_im = nim2_ff[NUMW-1];
      end
      anre3_in      = num_re[NUMW-1] ? NUMW'(-num_re) : NUMW'(num_re);
      anim3_in      = num_im[NUMW-1] ? NUMW'(-num_im) : NUMW'(num_im);
      ctl3_in.isdiv = isdiv;
      ctl3_in.dbz   = isdiv & dbz3;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl3_ff  <= ctl3_in;
         anre3_ff <= anre3_in;
         anim3_ff <= anim3_in;
         d3_ff    <= d3_in;
      end
   end

   // Stage 4: scaled dividends with the half-divisor added for rounding.
   ctl_type ctl4_ff;
   logic [RW-1:0] xre4_ff, xim4_ff;
   logic [DW-1:0] d4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl4_ff <= ctl3_ff;
         xre4_ff <= (RW'(anre3_ff) << F) + RW'(d3_ff >> 1);
         xim4_ff <= (RW'(anim3_ff) << F) + RW'(d3_ff >> 1);
         d4_ff   <= d3_ff;
      end
   end

   // Stage 5 and the restoring divider: a quotient that would not fit QB bits is
   // flagged up front and saturates later.
   logic [RW-1:0] rre_ff [0:QB];
   logic [RW-1:0] rim_ff [0:QB];
   logic [QB-1:0] qre_ff [0:QB];
   logic [QB-1:0] qim_ff [0:QB];
   logic [DW-1:0] dd_ff [0:QB];
   logic          ovre_ff [0:QB];
   logic          ovim_ff [0:QB];
   ctl_type       dctl_ff [0:QB];

   always_ff @(posedge clock) begin
      if (adv) begin
         rre_ff[0]  <= xre4_ff;
         rim_ff[0]  <= xim4_ff;
         qre_ff[0]  <= '0;
         qim_ff[0]  <= '0;
         dd_ff[0]   <= d4_ff;
         ovre_ff[0] <= xre4_ff >= (RW'(d4_ff) << QB);
         ovim_ff[0] <= xim4_ff >= (RW'(d4_ff) << QB);
         dctl_ff[0] <= ctl4_ff;
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_div
      localparam int K = QB - j;
      logic [RW-1:0] dsh;
      assign dsh = RW'(dd_ff[j-1]) << K;

      always_ff @(posedge clock) begin
         if (adv) begin
            dd_ff[j]   <= dd_ff[j-1];
            ovre_ff[j] <= ovre_ff[j-1];
            ovim_ff[j] <= ovim_ff[j-1];
            dctl_ff[j] <= dctl_ff[j-1];
            if (rre_ff[j-1] >= dsh) begin
               rre_ff[j] <= rre_ff[j-1] - dsh;
               qre_ff[j] <= qre_ff[j-1] | (QB'(1) << K);
            end else begin
               rre_ff[j] <= rre_ff[j-1];
               qre_ff[j] <= qre_ff[j-1];
            end
            if (rim_ff[j-1] >= dsh) begin
               rim_ff[j] <= rim_ff[j-1] - dsh;
               qim_ff[j] <= qim_ff[j-1] | (QB'(1) << K);
            end else begin
               rim_ff[j] <= rim_ff[j-1];
               qim_ff[j] <= qim_ff[j-1];
            end
         end
      end
   end

   // Saturation stage.
   ctl_type dc;
   logic [QB-1:0] qre_f, qim_f;
   logic signed [PW-1:0] qre_e, qim_e, pre_re, pre_im;
   res_type sat_in, sat_ff;

   always_comb begin
      dc    = dctl_ff[QB];
      qre_f = ovre_ff[QB] ? '1 : qre_ff[QB];
      qim_f = ovim_ff[QB] ? '1 : qim_ff[QB];
      qre_e = PW'(qre_f);
      qim_e = PW'(qim_f);
      if (!dc.isdiv) begin
         pre_re = dc.val_re;
         pre_im = dc.val_im;
      end else if (dc.dbz) begin
         pre_re = '0;
         pre_im = '0;
      end else begin
         pre_re = dc.neg_re ? -qre_e : qre_e;
         pre_im = dc.neg_im ? -qim_e : qim_e;
      end
      sat_in.ovf = 1'b0;
      sat_in.dbz = dc.dbz;
      sat_in.re  = W'(pre_re);
      sat_in.im  = W'(pre_im);
      if (pre_re > MAXV) begin
         sat_in.re  = W'(MAXV);
         sat_in.ovf = 1'b1;
      end else if (pre_re < MINV) begin
         sat_in.re  = W'(MINV);
         sat_in.ovf = 1'b1;
      end
      if (pre_im > MAXV) begin
         sat_in.im  = W'(MAXV);
         sat_in.ovf = 1'b1;
      end else if (pre_im < MINV) begin
         sat_in.im  = W'(MINV);
         sat_in.ovf = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sat_ff <= sat_in;
      end
   end

   // Squares, then their sum feeds the square root.
   res_type sq_ff;
   logic [DW-1:0] sqre_ff, sqim_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff   <= sat_ff;
         sqre_ff <= DW'(sat_ff.re * sat_ff.re);
         sqim_ff <= DW'(sat_ff.im * sat_ff.im);
      end
   end

   logic [DW-1:0] srem_ff [0:W];
   logic [DW-1:0] sroot_ff [0:W];
   res_type       sres_ff [0:W];

   always_ff @(posedge clock) begin
      if (adv) begin
         srem_ff[0]  <= sqre_ff + sqim_ff;
         sroot_ff[0] <= '0;
         sres_ff[0]  <= sq_ff;
      end
   end

   for (genvar j = 1; j <= W; j++) begin : g_sqrt
      localparam int K = W - j;
      logic [DW-1:0] sbit;
      logic [DW:0]   trial;
      assign sbit  = DW'(1) << (2*K);
      assign trial = {1'b0, sroot_ff[j-1]} + {1'b0, sbit};

      always_ff @(posedge clock) begin
         if (adv) begin
            sres_ff[j] <= sres_ff[j-1];
            if ({1'b0, srem_ff[j-1]} >= trial) begin
               srem_ff[j]  <= srem_ff[j-1] - DW'(trial);
               sroot_ff[j] <= (sroot_ff[j-1] >> 1) + sbit;
            end else begin
               srem_ff[j]  <= srem_ff[j-1];
               sroot_ff[j] <= sroot_ff[j-1] >> 1;
            end
         end
      end
   end

   // Magnitude rounding and saturation.
   logic [DW-1:0] mag_r;
   fin_type mg_in, mg_ff;

   always_comb begin
      mag_r    = sroot_ff[W] + DW'(srem_ff[W] > sroot_ff[W]);
      mg_in.r  = sres_ff[W];
      mg_in.mag = W'(mag_r);
      if (mag_r > UMAX) begin
         mg_in.mag   = '1;
         mg_in.r.ovf = 1'b1;
      end
      mg_in.zero = (sres_ff[W].re == '0) && (sres_ff[W].im == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mg_ff <= mg_in;
      end
   end

   // CORDIC vectoring; the left half plane is folded over first.
   logic signed [CW-1:0] cx_ff [0:CS];
   logic signed [CW-1:0] cy_ff [0:CS];
   logic signed [ZW-1:0] cz_ff [0:CS];
   fin_type              cf_ff [0:CS];
   logic signed [CW-1:0] x0, y0;

   assign x0 = CW'(mg_ff.r.re) <<< cap_pkg::GUARD_SHIFT;
   assign y0 = CW'(mg_ff.r.im) <<< cap_pkg::GUARD_SHIFT;

   always_ff @(posedge clock) begin
      if (adv) begin
         cf_ff[0] <= mg_ff;
         if (mg_ff.r.re[W-1]) begin
            cx_ff[0] <= -x0;
            cy_ff[0] <= -y0;
            cz_ff[0] <= mg_ff.r.im[W-1] ? -cap_pkg::PI_TBL : cap_pkg::PI_TBL;
         end else begin
            cx_ff[0] <= x0;
            cy_ff[0] <= y0;
            cz_ff[0] <= '0;
         end
      end
   end

   for (genvar j = 1; j <= CS; j++) begin : g_cordic
      localparam int I = j - 1;
      localparam logic signed [ZW-1:0] ATN = ZW'(cap_pkg::ATAN_TBL[I]);
      logic signed [CW-1:0] sx, sy;
      assign sx = cx_ff[j-1] >>> I;
      assign sy = cy_ff[j-1] >>> I;

      always_ff @(posedge clock) begin
         if (adv) begin
            cf_ff[j] <= cf_ff[j-1];
            if (!cy_ff[j-1][CW-1]) begin
               cx_ff[j] <= cx_ff[j-1] + sy;
               cy_ff[j] <= cy_ff[j-1] - sx;
               cz_ff[j] <= cz_ff[j-1] + ATN;
            end else begin
               cx_ff[j] <= cx_ff[j-1] - sy;
               cy_ff[j] <= cy_ff[j-1] + sx;
               cz_ff[j] <= cz_ff[j-1] - ATN;
            end
         end
      end
   end

   // Output stage: round the angle to Q2.(W-3), wrap it to (-pi, pi], and force it to zero for a zero vector.
   logic signed [ZW-1:0] zr, zw1, zw2;
   fin_type out_ff;
   logic [W-1:0] ang_ff;

   always_comb begin
      zr  = (cz_ff[CS] + HALFZ) >>> SH;
      zw1 = (zr > PIQ) ? zr - (PIQ <<< 1) : zr;
      zw2 = (zw1 <= -PIQ) ? zw1 + (PIQ <<< 1) : zw1;
      if (cf_ff[CS].zero) begin
         zw2 = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= cf_ff[CS];
         ang_ff <= W'(zw2);
      end
   end

   assign rsp_tdata = OW'({ang_ff, out_ff.mag, out_ff.r.im, out_ff.r.re});
   assign rsp_tuser = {out_ff.r.dbz, out_ff.r.ovf};

endmodule

`default_nettype wire

// ----- test/tb_complex_arith_polar_unit_top.sv -----
// Self-checking testbench for the complex arithmetic unit with polar results.
module tb_complex_arith_polar_unit_top;

   localparam int LIMIT_CYCLES = 300000;
   localparam int DRAIN_CYCLES = 120;
   localparam int RANDOM_ITEMS = 950;

   typedef struct {
      logic [3:0]         op;
      logic signed [15:0] a_re, a_im, b_re, b_im, scalar;
   } cplx_request_type;

   typedef struct {
      logic signed [15:0] re, im;
      logic [15:0]        mag;
      logic signed [15:0] ang;
      logic               ovf, dbz;
   } polar_result_type;

   class polar_scoreboard;
      polar_result_type pending[$];
      int errors = 0;
      int checked = 0;
      int dbz_seen = 0;
      int ovf_seen = 0;

      function longint div_near(longint n, longint d);
         longint un, ud, q;
         un = (n < 0) ? -n : n;
         ud = (d < 0) ? -d : d;
         q = (un + ud / 2) / ud;
         return ((n < 0) != (d < 0)) ? -q : q;
      endfunction

      function longint mul_near(longint p);
         return (p + 512) >>> 10;
      endfunction

      function longint clip(longint v, ref bit ovf);
         if (v > 32767) begin
            ovf = 1;
            return 32767;
         end
         if (v < -32768) begin
            ovf = 1;
            return -32768;
         end
         return v;
      endfunction

      function longint unsigned root_near(longint unsigned x);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         if (x > res) res++;
         return res;
      endfunction

      function longint phase_of(longint re, longint im);
         longint x, y, z, nx, pi_q;
         if (re == 0 && im == 0) return 0;
         x = re * 65536;
         y = im * 65536;
         z = 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = (im >= 0) ? longint'(cap_pkg::PI_TBL) : -longint'(cap_pkg::PI_TBL);
         end
         for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += longint'(cap_pkg::ATAN_TBL[i]);
            end else begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= longint'(cap_pkg::ATAN_TBL[i]);
            end
            x = nx;
         end
         z = (z + 65536) >>> 17;
         pi_q = (longint'(cap_pkg::PI_TBL) + 65536) >>> 17;
         if (z > pi_q) z -= 2 * pi_q;
         if (z <= -pi_q) z += 2 * pi_q;
         return z;
      endfunction

      function void note_request(cplx_request_type q);
         longint ar, ai, br, bi, r, re, im, den;
         longint unsigned m;
         bit ovf, dbz;
         polar_result_type e;
         ar = q.a_re; ai = q.a_im; br = q.b_re; bi = q.b_im; r = q.scalar;
         ovf = 0; dbz = 0;
         case (q.op)
            cap_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
            cap_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
            cap_pkg::OP_MUL: begin
               re = mul_near(ar * br - ai * bi);
               im = mul_near(ar * bi + ai * br);
            end
            cap_pkg::OP_DIV: begin
               den = br * br + bi * bi;
               if (den == 0) begin
                  dbz = 1; re = 0; im = 0;
               end else begin
                  re = div_near((ar * br + ai * bi) * 1024, den);
                  im = div_near((ai * br - ar * bi) * 1024, den);
               end
            end
            cap_pkg::OP_ADD_REAL: begin re = ar + r; im = ai; end
            cap_pkg::OP_SUB_REAL: begin re = ar - r; im = ai; end
            cap_pkg::OP_SCALE: begin re = mul_near(ar * r); im = mul_near(ai * r); end
            cap_pkg::OP_DIV_REAL: begin
               if (r == 0) begin
                  dbz = 1; re = 0; im = 0;
               end else begin
                  re = div_near(ar * 1024, r);
                  im = div_near(ai * 1024, r);
               end
            end
            default: begin re = ar; im = ai; end
         endcase
         re = clip(re, ovf);
         im = clip(im, ovf);
         m = root_near(longint'(re * re) + longint'(im * im));
         if (m > 65535) begin
            m = 65535;
            ovf = 1;
         end
         e.re = re[15:0];
         e.im = im[15:0];
         e.mag = m[15:0];
         e.ang = 16'(phase_of(re, im));
         e.ovf = ovf;
         e.dbz = dbz;
         pending.push_back(e);
      endfunction

      function void check_result(polar_result_type got);
         polar_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result re=%0d im=%0d", $time, got.re, got.im);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e.dbz) dbz_seen++;
         if (e.ovf) ovf_seen++;
         if (got.re !== e.re) begin
            $display("%0t: res_re expected %0d actual %0d", $time, e.re, got.re);
            errors++;
         end
         if (got.im !== e.im) begin
            $display("%0t: res_im expected %0d actual %0d", $time, e.im, got.im);
            errors++;
         end
         if (got.mag !== e.mag) begin
            $display("%0t: res_mag expected %0d actual %0d", $time, e.mag, got.mag);
            errors++;
         end
         if (got.ang !== e.ang) begin
            $display("%0t: res_angle expected %0d actual %0d", $time, e.ang, got.ang);
            errors++;
         end
         if (got.ovf !== e.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, got.ovf);
            errors++;
         end
         if (got.dbz !== e.dbz) begin
            $display("%0t: div_by_zero expected %0b actual %0b", $time, e.dbz, got.dbz);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [3:0]  req_tuser;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;
   logic [63:0] rsp_tdata;

   polar_scoreboard board;
   bit steady;
   int sent;
   int cycles;
   int stall_left;

   complex_arith_polar_unit_top uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   function int gap_length();
      int p;
      p = $urandom_range(99);
      if (steady || p < 70) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function logic signed [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(4096)) - 2048);
         3: return 16'(int'($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_request(cplx_request_type q);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= q.op;
      req_tdata <= {q.scalar, q.b_im, q.b_re, q.a_im, q.a_re};
      do @(posedge clock); while (!req_tready);
      board.note_request(q);
      sent++;
   endtask

   task automatic send_fields(logic [3:0] op, logic signed [15:0] ar, logic signed [15:0] ai,
                              logic signed [15:0] br, logic signed [15:0] bi,
                              logic signed [15:0] r);
      cplx_request_type q;
      q.op = op; q.a_re = ar; q.a_im = ai; q.b_re = br; q.b_im = bi; q.scalar = r;
      send_request(q);
   endtask

   // Result side: check every accepted result and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result('{re: rsp_tdata[15:0], im: rsp_tdata[31:16],
                              mag: rsp_tdata[47:32], ang: rsp_tdata[63:48],
                              ovf: rsp_tuser[0], dbz: rsp_tuser[1]});
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!steady && $urandom_range(99) < 15) begin
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(10, 50)
                                                 : $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      cplx_request_type q;
      board = new();
      clock = 1'b0;
      reset = 1'b1;
      cycles = 0;
      stall_left = 0;
      steady = 0;
      sent = 0;
      req_tvalid = 1'b0;
      req_tuser = cap_pkg::OP_PASS;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: every opcode, field extremes and the special cases.
      send_fields(cap_pkg::OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
      send_fields(cap_pkg::OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
      send_fields(cap_pkg::OP_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 0);
      send_fields(cap_pkg::OP_SUB, 1024, 0, 1024, 0, 0);
      send_fields(cap_pkg::OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
      send_fields(cap_pkg::OP_MUL, 1024, 512, -2048, 300, 0);
      send_fields(cap_pkg::OP_DIV, 16'sh7fff, 16'sh8000, 1, 0, 0);
      send_fields(cap_pkg::OP_DIV, 1024, 2048, 0, 0, 16'sh7fff);
      send_fields(cap_pkg::OP_DIV, 3000, -700, 1500, 900, 0);
      send_fields(cap_pkg::OP_ADD_REAL, 16'sh7fff, 5, 0, 0, 16'sh7fff);
      send_fields(cap_pkg::OP_SUB_REAL, 16'sh8000, -5, 0, 0, 16'sh7fff);
      send_fields(cap_pkg::OP_SCALE, 16'sh8000, 16'sh7fff, 0, 0, 16'sh8000);
      send_fields(cap_pkg::OP_SCALE, 700, -300, 0, 0, -1536);
      send_fields(cap_pkg::OP_DIV_REAL, 1024, 1024, 16'sh7fff, 16'sh7fff, 0);
      send_fields(cap_pkg::OP_DIV_REAL, 16'sh7fff, -3, 0, 0, -1);
      send_fields(cap_pkg::OP_PASS, 0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_fields(cap_pkg::OP_PASS, -1024, 0, 0, 0, 0);
      send_fields(cap_pkg::OP_PASS, 16'sh8000, 0, 0, 0, 0);
      send_fields(cap_pkg::OP_PASS, 0, 16'sh8000, 0, 0, 0);
      send_fields(4'd9, 100, -200, 5, 5, 5);
      send_fields(4'd15, 16'sh8000, 16'sh7fff, 0, 0, 0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 300 && n < 400);
         if (n == 600) begin
            req_tvalid <= 1'b0;
            while (board.pending.size() != 0) @(posedge clock);
         end
         q.op = ($urandom_range(19) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
         q.a_re = pick_value();
         q.a_im = pick_value();
         q.b_re = pick_value();
         q.b_im = pick_value();
         q.scalar = pick_value();
         if ($urandom_range(29) == 0) begin
            q.b_re = 0;
            q.b_im = 0;
            q.scalar = 0;
         end
         send_request(q);
      end
      steady = 0;
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests over all opcodes; %0d results checked.", sent, board.checked);
      $display("Of those, %0d had a zero divisor and %0d saturated.",
               board.dbz_seen, board.ovf_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
